### rtl/rational_arithmetic_unit_top_assert.svh
// Assertion macros for the rational arithmetic unit.
// Used by rau_back, the RTL file that checks itself; needs no other file.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RAU_NEVER(label, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RAU_ASSERT(label, rst_n, prop, msg)
`define RAU_NEVER(label, rst_n, cond, msg)
`endif
`endif

### rtl/rau_pkg.sv
// Shared types and constants of the rational arithmetic unit.
// No dependencies.
`default_nettype none
package rau_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int IO_BITS = 32;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERODEN = 2'd1,
        ST_DIVZERO = 2'd2
    } status_t;

    // divider operation select
    typedef enum logic [1:0] {
        DV_QUO = 2'd0,
        DV_REM = 2'd1
    } dvop_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_MUL1, B_MUL1W,
        B_G1, B_G1W,
        B_LDIV, B_LDIVW,
        B_Q1, B_Q1W,
        B_Q2, B_Q2W,
        B_T1, B_T1W,
        B_T2, B_T2W,
        B_SUM,
        B_MUL2, B_MUL2W,
        B_CHK,
        B_G2, B_G2W,
        B_RN, B_RNW,
        B_RD, B_RDW,
        B_OUT
    } bstate_t;
endpackage
`default_nettype wire

### rtl/rau_div.sv
// Iterative signed divider: one quotient bit per cycle, truncating, C remainder sign.
// Depends on rau_pkg.
`default_nettype none
module rau_div #(
    parameter int W = rau_pkg::WORD_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         go,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quo,
    output logic [W-1:0]      rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic          sq_reg, sq_next, sr_reg, sr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        sq_next   = sq_reg;
        sr_next   = sr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};
        if (go)
        begin
            q_next    = dividend[W-1] ? (~dividend + 1'b1) : dividend;
            d_next    = divisor[W-1] ? (~divisor + 1'b1) : divisor;
            r_next    = '0;
            sq_next   = dividend[W-1] ^ divisor[W-1];
            sr_next   = dividend[W-1];
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[W-1:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        r_reg  <= r_next;
        d_reg  <= d_next;
        sq_reg <= sq_next;
        sr_reg <= sr_next;
    end

    // divisor of zero yields zero
    always_comb
    begin
        done = done_reg;
        if (d_reg == '0)
        begin
            quo = '0;
            rem = '0;
        end
        else
        begin
            quo = sq_reg ? (~q_reg + 1'b1) : q_reg;
            rem = sr_reg ? (~r_reg[W-1:0] + 1'b1) : r_reg[W-1:0];
        end
    end
endmodule
`default_nettype wire

### rtl/rau_front.sv
// Front end: accepts commands, screens zero denominators and zero divisors, queues operands.
// Depends on rau_pkg.
`default_nettype none
module rau_front #(
    parameter int W = rau_pkg::WORD_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [1:0]   cmd,
    input  wire logic [31:0]  a_num,
    input  wire logic [31:0]  a_den,
    input  wire logic [31:0]  b_num,
    input  wire logic [31:0]  b_den,
    output logic              q_valid,
    input  wire logic         q_pop,
    output logic [1:0]        q_cmd,
    output logic [1:0]        q_stat,
    output logic [W-1:0]      q_an,
    output logic [W-1:0]      q_ad,
    output logic [W-1:0]      q_bn,
    output logic [W-1:0]      q_bd
);
    localparam int QW = 4 + 4 * W;

    logic [QW-1:0] mem_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          wp_reg, rp_reg;
    logic          push;
    logic [W-1:0]  an, ad, bn, bd;
    logic [1:0]    st;

    function automatic logic [W-1:0] ld(input logic [31:0] v);
        logic [63:0] x;
        x = {{32{v[31]}}, v};
        return x[W-1:0];
    endfunction

    always_comb
    begin
        an = ld(a_num);
        ad = ld(a_den);
        bn = ld(b_num);
        bd = ld(b_den);
        if (ad == '0 || bd == '0)
            st = rau_pkg::ST_ZERODEN;
        else if (rau_pkg::cmd_t'(cmd) == rau_pkg::CMD_DIV && bn == '0)
            st = rau_pkg::ST_DIVZERO;
        else
            st = rau_pkg::ST_OK;
    end

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign {q_cmd, q_stat, q_an, q_ad, q_bn, q_bd} = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= !wp_reg;
            if (q_pop)
                rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= {cmd, st, an, ad, bn, bd};
    end
endmodule
`default_nettype wire

### rtl/rau_back.sv
// Back end sequencer: LCM, cross products and Euclid reduction on one shared divider.
// Depends on rau_pkg, rau_div and the assertion header.
`default_nettype none
`include "rational_arithmetic_unit_top_assert.svh"
module rau_back #(
    parameter int W = rau_pkg::WORD_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire logic [1:0]  q_cmd,
    input  wire logic [1:0]  q_stat,
    input  wire logic [W-1:0] q_an,
    input  wire logic [W-1:0] q_ad,
    input  wire logic [W-1:0] q_bn,
    input  wire logic [W-1:0] q_bd,
    output logic             res_valid,
    output logic [31:0]      res_num,
    output logic [31:0]      res_den,
    output logic [1:0]       status
);
    rau_pkg::bstate_t st_reg, st_next, ret_reg, ret_next;

    logic [1:0]   cmd_reg, stat_reg, stat_next;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0] x_reg, x_next, y_reg, y_next;   // gcd working pair
    logic [W-1:0] l_reg, l_next, n_reg, n_next, d_reg, d_next;
    logic [W-1:0] t1_reg, t1_next, p_reg, p_next;
    logic [W-1:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [W-1:0] dvn_reg, dvn_next, dvd_reg, dvd_next;
    logic         go, dv_done, load;
    logic [W-1:0] quo, rem;
    logic [2*W-1:0] prod;
    logic         ov_reg, ov_next;

    assign prod = ma_reg * mb_reg;

    rau_div #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .go(go), .dividend(dvn_reg), .divisor(dvd_reg),
        .done(dv_done), .quo(quo), .rem(rem)
    );

    always_comb
    begin
        st_next   = st_reg;
        ret_next  = ret_reg;
        stat_next = stat_reg;
        x_next = x_reg; y_next = y_reg; l_next = l_reg; n_next = n_reg; d_next = d_reg;
        t1_next = t1_reg; p_next = prod[W-1:0];
        ma_next = ma_reg; mb_next = mb_reg; dvn_next = dvn_reg; dvd_next = dvd_reg;
        ov_next = ov_reg;
        go = 1'b0; q_pop = 1'b0; load = 1'b0; res_valid = 1'b0;
        unique case (st_reg)
            rau_pkg::B_IDLE:
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    load = 1'b1;
                    stat_next = q_stat;
                    if (q_stat != rau_pkg::ST_OK)
                        st_next = rau_pkg::B_OUT;
                    else if (q_cmd == rau_pkg::CMD_ADD || q_cmd == rau_pkg::CMD_SUB)
                    begin
                        ma_next = q_ad; mb_next = q_bd;
                        x_next = q_ad; y_next = q_bd;
                        st_next = rau_pkg::B_MUL1;
                    end
                    else
                    begin
                        ma_next = q_an;
                        mb_next = (q_cmd == rau_pkg::CMD_MUL) ? q_bn : q_bd;
                        st_next = rau_pkg::B_MUL2;
                    end
                end
            rau_pkg::B_MUL1:  st_next = rau_pkg::B_MUL1W;
            rau_pkg::B_MUL1W:
            begin
                l_next = p_reg;  // a_den*b_den, divided by gcd later
                ret_next = rau_pkg::B_LDIV;
                st_next = rau_pkg::B_G1;
            end
            // Euclid loop, shared by both gcds; result lands in x
            rau_pkg::B_G1:
                if (y_reg == '0)
                    st_next = ret_reg;
                else
                begin
                    dvn_next = x_reg; dvd_next = y_reg;
                    st_next = rau_pkg::B_G1W;
                end
            rau_pkg::B_G1W:
                if (!ov_reg)
                begin
                    go = 1'b1; ov_next = 1'b1;
                end
                else if (dv_done)
                begin
                    ov_next = 1'b0;
                    x_next = y_reg; y_next = rem;
                    st_next = rau_pkg::B_G1;
                end
            rau_pkg::B_LDIV:
            begin
                dvn_next = l_reg; dvd_next = x_reg;
                st_next = rau_pkg::B_LDIVW;
            end
            rau_pkg::B_Q1:
            begin
                dvn_next = l_reg; dvd_next = ad_reg;
                st_next = rau_pkg::B_Q1W;
            end
            rau_pkg::B_Q2:
            begin
                dvn_next = l_reg; dvd_next = bd_reg;
                st_next = rau_pkg::B_Q2W;
            end
            rau_pkg::B_LDIVW, rau_pkg::B_Q1W, rau_pkg::B_Q2W, rau_pkg::B_RNW, rau_pkg::B_RDW:
                if (!ov_reg)
                begin
                    go = 1'b1; ov_next = 1'b1;
                end
                else if (dv_done)
                begin
                    ov_next = 1'b0;
                    unique case (st_reg)
                        rau_pkg::B_LDIVW:
                        begin
                            l_next = quo; st_next = rau_pkg::B_Q1;
                        end
                        rau_pkg::B_Q1W:
                        begin
                            ma_next = an_reg; mb_next = quo; st_next = rau_pkg::B_T1;
                        end
                        rau_pkg::B_Q2W:
                        begin
                            ma_next = bn_reg; mb_next = quo; st_next = rau_pkg::B_T2;
                        end
                        rau_pkg::B_RNW:
                        begin
                            n_next = quo; st_next = rau_pkg::B_RD;
                        end
                        default:
                        begin
                            d_next = quo; st_next = rau_pkg::B_OUT;
                        end
                    endcase
                end
            rau_pkg::B_T1:  st_next = rau_pkg::B_T1W;
            rau_pkg::B_T1W:
            begin
                t1_next = p_reg; st_next = rau_pkg::B_Q2;
            end
            rau_pkg::B_T2:  st_next = rau_pkg::B_T2W;
            rau_pkg::B_T2W: st_next = rau_pkg::B_SUM;
            rau_pkg::B_SUM:
            begin
                n_next = (cmd_reg == rau_pkg::CMD_ADD) ? t1_reg + p_reg : t1_reg - p_reg;
                d_next = l_reg;
                st_next = rau_pkg::B_CHK;
            end
            rau_pkg::B_MUL2:
            begin
                ma_next = ad_reg;
                mb_next = (cmd_reg == rau_pkg::CMD_MUL) ? bd_reg : bn_reg;
                st_next = rau_pkg::B_MUL2W;
            end
            rau_pkg::B_MUL2W:
            begin
                n_next = p_reg;       // numerator product
                st_next = rau_pkg::B_T2;
                ret_next = rau_pkg::B_CHK;
                st_next = rau_pkg::B_SUM;
                // reuse: denominator product arrives next cycle
                st_next = rau_pkg::B_T2W;
            end
            rau_pkg::B_CHK:
                if (d_reg == '0)
                begin
                    stat_next = rau_pkg::ST_ZERODEN;
                    st_next = rau_pkg::B_OUT;
                end
                else
                begin
                    x_next = n_reg; y_next = d_reg;
                    ret_next = rau_pkg::B_RN;
                    st_next = rau_pkg::B_G2;
                end
            rau_pkg::B_G2:  st_next = rau_pkg::B_G1;
            rau_pkg::B_G2W: st_next = rau_pkg::B_G1;
            rau_pkg::B_RN:
            begin
                dvn_next = n_reg; dvd_next = x_reg;
                st_next = rau_pkg::B_RNW;
            end
            rau_pkg::B_RD:
            begin
                dvn_next = d_reg; dvd_next = x_reg;
                st_next = rau_pkg::B_RDW;
            end
            rau_pkg::B_OUT:
            begin
                res_valid = 1'b1;
                st_next = rau_pkg::B_IDLE;
            end
            default: st_next = rau_pkg::B_IDLE;
        endcase
        // multiply path: T2W after MUL2W captures denominator product
        if (st_reg == rau_pkg::B_T2W && cmd_reg[1])
        begin
            d_next = p_reg;
            st_next = rau_pkg::B_CHK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= rau_pkg::B_IDLE;
            ret_reg  <= rau_pkg::B_IDLE;
            ov_reg   <= 1'b0;
            stat_reg <= rau_pkg::ST_OK;
        end
        else
        begin
            st_reg   <= st_next;
            ret_reg  <= ret_next;
            ov_reg   <= ov_next;
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= q_cmd;
            an_reg <= q_an; ad_reg <= q_ad; bn_reg <= q_bn; bd_reg <= q_bd;
        end
        x_reg <= x_next; y_reg <= y_next; l_reg <= l_next; n_reg <= n_next;
        d_reg <= d_next; t1_reg <= t1_next; p_reg <= p_next;
        ma_reg <= ma_next; mb_reg <= mb_next; dvn_reg <= dvn_next; dvd_reg <= dvd_next;
    end

    // widen to 32 bits by sign extension, cut if wider
    logic [63:0] on_w, od_w;
    always_comb
    begin
        on_w = {{(64-W){n_reg[W-1]}}, n_reg};
        od_w = {{(64-W){d_reg[W-1]}}, d_reg};
        if (stat_reg != rau_pkg::ST_OK)
        begin
            res_num = '0;
            res_den = 32'd1;
        end
        else
        begin
            res_num = on_w[31:0];
            res_den = od_w[31:0];
        end
        status = stat_reg;
    end

    `RAU_NEVER(a_pop_busy, rst_n, q_pop && st_reg != rau_pkg::B_IDLE, "pop outside idle")
    `RAU_NEVER(a_go_twice, rst_n, go && ov_reg, "divider restarted")
    `RAU_ASSERT(a_out_idle, rst_n, res_valid |=> st_reg == rau_pkg::B_IDLE, "no return to idle")
endmodule
`default_nettype wire

### rtl/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_front, rau_back, rau_div.
//
// Issue a command by raising start with cmd and both fractions while busy is low;
// the word is taken at that edge. A two-entry queue holds words in front of the
// arithmetic back end, so busy rises only when both entries are full. Each result
// appears on res_num, res_den and status for exactly one cycle, marked by done;
// the receiver must take it then, it cannot hold results off. Latency is data
// dependent: every modulo or quotient step runs on one shared bit-serial divider;
// add and subtract run the gcd loop twice plus five divisions, multiply and divide
// run it once plus two; commands screened as errors on input skip the divider.
`default_nettype none
module rational_arithmetic_unit_top #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] a_num,
    input  wire logic [31:0] a_den,
    input  wire logic [31:0] b_num,
    input  wire logic [31:0] b_den,
    output logic             done,
    output logic [31:0]      res_num,
    output logic [31:0]      res_den,
    output logic [1:0]       status
);
    logic                 q_valid, q_pop;
    logic [1:0]           q_cmd, q_stat;
    logic [WORD_BITS-1:0] q_an, q_ad, q_bn, q_bd;

    // hold incoming words and classify them
    rau_front #(.W(WORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_stat(q_stat),
        .q_an(q_an), .q_ad(q_ad), .q_bn(q_bn), .q_bd(q_bd)
    );

    // advance one word at a time through the arithmetic
    rau_back #(.W(WORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_cmd(q_cmd), .q_stat(q_stat), .q_an(q_an), .q_ad(q_ad),
        .q_bn(q_bn), .q_bd(q_bd), .res_valid(done), .res_num(res_num),
        .res_den(res_den), .status(status)
    );
endmodule
`default_nettype wire
